[src/ksw_pkg.sv]
`timescale 1ns / 1ps
package ksw_pkg;

  // field widths
  localparam int WORD_W     = 64;
  localparam int INTERVAL_W = 4;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = 2;

  // register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EMIT_PARTIAL  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ANCHOR_OLDEST = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_MAIN,
    S_TAIL
  } ksw_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // take the input row
    logic emit;        // push one beat into the output register
    logic tail_begin;  // point at the first tail window
    logic tail_next;   // move to the next tail window
    logic last;        // current window is the last of the run
  } ksw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_main;     // row produces a main window
    logic has_tail;     // row produces tail windows
    logic window_last;  // cursor is on the last row of its window
    logic tail_final;   // current tail window is the final one
    logic out_free;     // output register can take a beat
  } ksw_status_t;

endpackage

[src/keyed_sliding_window_expander.sv]
`timescale 1ns / 1ps
// channel    dir  beat contents
// s_axis     in   tdata: anchor_word, row_word; tlast: group_end
// m_axis     out  tdata: window_anchor, window_row; tuser: window_last; tlast: run_last
// apb        in   interval (0x0), emit_partial (0x4), anchor_oldest (0x8)
//
// a row is taken in S_IDLE and dispatched in S_START, then the walk emits its
// result beats: interval beats for a full window, plus the tail windows at a
// group end; a row with no results goes back to S_IDLE from S_START
// the single output register paces the walk: a stalled m_axis holds the walk
// reset is synchronous and active high; ring contents are not cleared
module keyed_sliding_window_expander #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [127:0]               s_axis_tdata,  // anchor_word, row_word
  input  logic                       s_axis_tlast,  // group_end
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [127:0]               m_axis_tdata,  // window_anchor, window_row
  output logic                       m_axis_tuser,  // window_last
  output logic                       m_axis_tlast,  // run_last
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ksw_pkg::ADDR_W-1:0] paddr,
  input  logic [ksw_pkg::DATA_W-1:0] pwdata,
  output logic [ksw_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ksw_pkg::*;

  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1);

  logic [LW-1:0]     len;
  logic              emit_partial;
  logic              anchor_oldest;
  logic              interval_wr;
  ksw_cmd_t          cmd;
  ksw_status_t       st;
  logic [WORD_W-1:0] window_anchor;
  logic [WORD_W-1:0] window_row;

  ksw_regs #(
    .MAX_WINDOW (MAX_WINDOW),
    .LW         (LW)
  ) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .len           (len),
    .emit_partial  (emit_partial),
    .anchor_oldest (anchor_oldest),
    .interval_wr   (interval_wr)
  );

  ksw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ksw_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SW         (SW),
    .LW         (LW)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .len               (len),
    .emit_partial      (emit_partial),
    .anchor_oldest     (anchor_oldest),
    .interval_wr       (interval_wr),
    .in_anchor_word    (s_axis_tdata[WORD_W-1:0]),
    .in_row_word       (s_axis_tdata[2*WORD_W-1:WORD_W]),
    .in_group_end      (s_axis_tlast),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_window_anchor (window_anchor),
    .out_window_row    (window_row),
    .out_window_last   (m_axis_tuser),
    .out_run_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {window_row, window_anchor};

endmodule

[src/ksw_regs.sv]
`timescale 1ns / 1ps
module ksw_regs #(
  parameter int MAX_WINDOW = 8,
  parameter int LW         = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ksw_pkg::ADDR_W-1:0] paddr,
  input  logic [ksw_pkg::DATA_W-1:0] pwdata,
  output logic [ksw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [LW-1:0]              len,
  output logic                       emit_partial,
  output logic                       anchor_oldest,
  output logic                       interval_wr
);
  import ksw_pkg::*;

  logic [INTERVAL_W-1:0] interval;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr      = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      interval      <= INTERVAL_W'(1);
      emit_partial  <= 1'b0;
      anchor_oldest <= 1'b0;
    end else if (wr) begin
      if (reg_idx == REG_INTERVAL) begin
        interval <= pwdata[INTERVAL_W-1:0];
      end
      if (reg_idx == REG_EMIT_PARTIAL) begin
        emit_partial <= pwdata[0];
      end
      if (reg_idx == REG_ANCHOR_OLDEST) begin
        anchor_oldest <= pwdata[0];
      end
    end
  end

  // interval write restarts the ring
  assign interval_wr = wr && (reg_idx == REG_INTERVAL);

  // effective window length: zero acts as one, saturate at ring depth
  always_comb begin
    if (interval == '0) begin
      len = LW'(1);
    end else if (interval > INTERVAL_W'(MAX_WINDOW)) begin
      len = LW'(MAX_WINDOW);
    end else begin
      len = LW'(interval);
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_INTERVAL:      prdata = DATA_W'(interval);
      REG_EMIT_PARTIAL:  prdata = DATA_W'(emit_partial);
      REG_ANCHOR_OLDEST: prdata = DATA_W'(anchor_oldest);
      default:           prdata = '0;
    endcase
  end

endmodule

[src/ksw_dp.sv]
`timescale 1ns / 1ps
module ksw_dp #(
  parameter int MAX_WINDOW = 8,
  parameter int SW         = 3,
  parameter int LW         = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [LW-1:0]              len,
  input  logic                       emit_partial,
  input  logic                       anchor_oldest,
  input  logic                       interval_wr,
  input  logic [ksw_pkg::WORD_W-1:0] in_anchor_word,
  input  logic [ksw_pkg::WORD_W-1:0] in_row_word,
  input  logic                       in_group_end,
  input  ksw_pkg::ksw_cmd_t          cmd,
  output ksw_pkg::ksw_status_t       st,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ksw_pkg::WORD_W-1:0] out_window_anchor,
  output logic [ksw_pkg::WORD_W-1:0] out_window_row,
  output logic                       out_window_last,
  output logic                       out_run_last
);
  import ksw_pkg::*;

  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] p, input logic [LW-1:0] l);
    logic [LW:0] s;
    s = (LW+1)'(p) + (LW+1)'(1);
    return (s >= {1'b0, l}) ? '0 : s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] p, input logic [LW-1:0] l);
    return (p == '0) ? SW'(l - LW'(1)) : p - SW'(1);
  endfunction

  // ring storage
  logic [WORD_W-1:0] anchor_ring [MAX_WINDOW];
  logic [WORD_W-1:0] row_ring    [MAX_WINDOW];

  // position state
  logic [SW-1:0] write_slot;
  logic          ring_full;

  // window walk registers
  logic [SW-1:0] cursor;
  logic [SW-1:0] stop;
  logic [SW-1:0] win_start;
  logic [SW-1:0] anc;
  logic [SW-1:0] tail_first;
  logic          has_main;
  logic          has_tail;

  // placement of the incoming row
  logic [SW-1:0] pos_in;
  logic [SW-1:0] pos_new;
  logic          full_new;
  logic [SW-1:0] tail_first_c;
  logic [SW-1:0] anc_first_c;
  logic [SW-1:0] cursor_first_c;
  logic          has_main_c;
  logic          has_tail_c;
  logic [SW-1:0] cursor_nx;
  logic [SW-1:0] win_start_nx;
  logic          wlast;

  always_comb begin
    pos_in         = ({1'b0, LW'(write_slot)} >= {1'b0, len}) ? '0 : write_slot;
    pos_new        = slot_next(pos_in, len);
    full_new       = ring_full || (pos_new == '0);
    tail_first_c   = full_new ? slot_next(pos_new, len) : '0;
    anc_first_c    = (full_new && anchor_oldest) ? pos_new : slot_prev(pos_new, len);
    cursor_first_c = full_new ? pos_new : '0;
    has_main_c     = full_new || (emit_partial && !anchor_oldest);
    has_tail_c     = in_group_end && emit_partial && anchor_oldest
                     && (tail_first_c != pos_new);
    cursor_nx      = slot_next(cursor, len);
    win_start_nx   = slot_next(win_start, len);
    wlast          = (cursor_nx == stop);
  end

  // ring write
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      anchor_ring[pos_in] <= in_anchor_word;
      row_ring[pos_in]    <= in_row_word;
    end
  end

  // write position and full flag
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      ring_full  <= 1'b0;
    end else if (interval_wr) begin
      write_slot <= '0;
      ring_full  <= 1'b0;
    end else if (cmd.load) begin
      write_slot <= in_group_end ? '0 : pos_new;
      ring_full  <= in_group_end ? 1'b0 : full_new;
    end
  end

  // window walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stop       <= pos_new;
      cursor     <= cursor_first_c;
      anc        <= anc_first_c;
      tail_first <= tail_first_c;
      has_main   <= has_main_c;
      has_tail   <= has_tail_c;
    end else if (cmd.tail_begin) begin
      cursor    <= tail_first;
      win_start <= tail_first;
      anc       <= tail_first;
    end else if (cmd.tail_next) begin
      cursor    <= win_start_nx;
      win_start <= win_start_nx;
      anc       <= win_start_nx;
    end else if (cmd.emit) begin
      cursor <= cursor_nx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_window_anchor <= anchor_ring[anc];
      out_window_row    <= row_ring[cursor];
      out_window_last   <= wlast;
      out_run_last      <= wlast && cmd.last;
    end
  end

  // status
  always_comb begin
    st.has_main    = has_main;
    st.has_tail    = has_tail;
    st.window_last = wlast;
    st.tail_final  = (win_start_nx == stop);
    st.out_free    = !out_valid || out_ready;
  end

endmodule

[src/ksw_ctrl.sv]
`timescale 1ns / 1ps
module ksw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ksw_pkg::ksw_status_t st,
  output ksw_pkg::ksw_cmd_t    cmd
);
  import ksw_pkg::*;

  ksw_state_t state;
  ksw_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (st.has_main) begin
          state_next = S_MAIN;
        end else if (st.has_tail) begin
          cmd.tail_begin = 1'b1;
          state_next     = S_TAIL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MAIN: begin
        cmd.last = !st.has_tail;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.window_last) begin
            if (st.has_tail) begin
              cmd.tail_begin = 1'b1;
              state_next     = S_TAIL;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_TAIL: begin
        cmd.last = st.tail_final;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.window_last) begin
            if (st.tail_final) begin
              state_next = S_IDLE;
            end else begin
              cmd.tail_next = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[tb/sv/keyed_sliding_window_expander_tb.sv]
`timescale 1ns / 1ps
module keyed_sliding_window_expander_tb;
  import ksw_pkg::*;

  localparam int RING_DEPTH  = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYC  = 6;

  // one input row and one window beat as they travel on the streams
  typedef struct packed {
    logic [WORD_W-1:0] anchor_word;
    logic [WORD_W-1:0] row_word;
    logic              group_end;
  } row_t;

  typedef struct packed {
    logic [WORD_W-1:0] window_anchor;
    logic [WORD_W-1:0] window_row;
    logic              window_last;
    logic              run_last;
  } beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [127:0]        s_axis_tdata = '0;   // anchor_word, row_word
  logic                s_axis_tlast = 1'b0; // group_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [127:0]        m_axis_tdata;        // window_anchor, window_row
  logic                m_axis_tuser;        // window_last
  logic                m_axis_tlast;        // run_last
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  keyed_sliding_window_expander #(
    .MAX_WINDOW(RING_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  always #10 clk = ~clk;

  // rows waiting to be sent and window beats still owed by the block
  row_t  row_backlog[$];
  beat_t due_beats[$];

  // shadow copy of the ring and the registers
  logic [WORD_W-1:0] ring_anchor[RING_DEPTH];
  logic [WORD_W-1:0] ring_row[RING_DEPTH];
  int unsigned       wr_slot = 0;
  logic              full_flag = 1'b0;
  logic [3:0]        cfg_interval = 4'd1;
  logic              cfg_partial = 1'b0;
  logic              cfg_oldest = 1'b0;

  int   err_count = 0;
  int   cycle_no = 0;
  int   stall_cycles = 0;
  logic in_taken = 1'b0;
  row_t next_row;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 100) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // random idling, with one quiet stretch
  function automatic logic idle_roll();
    if (cycle_no >= 1000 && cycle_no < 2000) return 1'b0;
    return $urandom_range(0, 99) < 8;
  endfunction

  function automatic int unsigned slot_after(int unsigned p, int unsigned len);
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  function automatic int unsigned slot_before(int unsigned p, int unsigned len);
    return (p == 0) ? len - 1 : p - 1;
  endfunction

  // queue the rows from start up to stop (exclusive, at least one) as one window
  function automatic int queue_window(int unsigned start, int unsigned stop,
                                      int unsigned anc, int unsigned len);
    int unsigned t;
    int unsigned nx;
    int          cnt;
    beat_t       b;
    t = start;
    cnt = 0;
    do begin
      nx = slot_after(t, len);
      b.window_anchor = ring_anchor[anc % RING_DEPTH];
      b.window_row = ring_row[t];
      b.window_last = (nx == stop);
      b.run_last = 1'b0;
      due_beats = {due_beats, b};
      cnt++;
      t = nx;
    end while (t != stop);
    return cnt;
  endfunction

  // store one row in the ring and queue every window beat it causes
  function automatic void expand_row(row_t rw);
    int unsigned len;
    int unsigned pos;
    int unsigned t;
    int          cnt;
    beat_t       tmp;
    if (cfg_interval == 0) len = 1;
    else if (cfg_interval > RING_DEPTH) len = RING_DEPTH;
    else len = cfg_interval;
    pos = wr_slot;
    if (pos >= len) pos = 0;
    ring_anchor[pos] = rw.anchor_word;
    ring_row[pos] = rw.row_word;
    pos = slot_after(pos, len);
    if (pos == 0) full_flag = 1'b1;
    cnt = 0;
    if (full_flag) begin
      cnt += queue_window(pos, pos, cfg_oldest ? pos : slot_before(pos, len), len);
    end else if (cfg_partial && !cfg_oldest) begin
      cnt += queue_window(0, pos, slot_before(pos, len), len);
    end
    // group end: tail windows when anchored on the oldest row, then restart
    if (rw.group_end) begin
      if (cfg_partial && cfg_oldest) begin
        t = full_flag ? slot_after(pos, len) : 0;
        while (t != pos) begin
          cnt += queue_window(t, pos, t, len);
          t = slot_after(t, len);
        end
      end
      pos = 0;
      full_flag = 1'b0;
    end
    wr_slot = pos;
    if (cnt > 0) begin
      tmp = due_beats[due_beats.size() - 1];
      tmp.run_last = 1'b1;
      due_beats[due_beats.size() - 1] = tmp;
    end
  endfunction

  // input beat driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (row_backlog.size() != 0 && !idle_roll()) begin
        next_row = row_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {next_row.row_word, next_row.anchor_word};
        s_axis_tlast <= next_row.group_end;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    m_axis_tready <= rst ? 1'b0 : !idle_roll();
  end

  // monitor: predict on accepted rows, check accepted window beats
  always @(posedge clk) begin
    beat_t exp_b;
    row_t  got_row;
    logic  active;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      cycle_no++;
      active = 1'b0;
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        got_row.anchor_word = s_axis_tdata[63:0];
        got_row.row_word = s_axis_tdata[127:64];
        got_row.group_end = s_axis_tlast;
        expand_row(got_row);
        active = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat anchor %h row %h",
                                    m_axis_tdata[63:0], m_axis_tdata[127:64]));
        end else begin
          active = 1'b1;
          exp_b = due_beats.pop_front();
          if (m_axis_tdata[63:0] !== exp_b.window_anchor)
            report_mismatch($sformatf("window_anchor %h, expected %h",
                                      m_axis_tdata[63:0], exp_b.window_anchor));
          if (m_axis_tdata[127:64] !== exp_b.window_row)
            report_mismatch($sformatf("window_row %h, expected %h",
                                      m_axis_tdata[127:64], exp_b.window_row));
          if (m_axis_tuser !== exp_b.window_last)
            report_mismatch($sformatf("window_last %b, expected %b",
                                      m_axis_tuser, exp_b.window_last));
          if (m_axis_tlast !== exp_b.run_last)
            report_mismatch($sformatf("run_last %b, expected %b",
                                      m_axis_tlast, exp_b.run_last));
        end
      end
      if (psel && penable && pwrite && pready) active = 1'b1;
      // watchdog on cycles with no accepted beat or register write
      if (active) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // register write over the apb port, shadow copy updated along
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_INTERVAL: begin
        cfg_interval = value[3:0];
        wr_slot = 0;
        full_flag = 1'b0;
      end
      REG_EMIT_PARTIAL:  cfg_partial = value[0];
      REG_ANCHOR_OLDEST: cfg_oldest = value[0];
      default: ;
    endcase
  endtask

  // wait until every row is sent and every owed beat has come
  task automatic hold_until_drained();
    while (row_backlog.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] ivl, input logic [DATA_W-1:0] ep,
                            input logic [DATA_W-1:0] ao);
    hold_until_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    reg_write(REG_INTERVAL, ivl);
    reg_write(REG_EMIT_PARTIAL, ep);
    reg_write(REG_ANCHOR_OLDEST, ao);
  endtask

  task automatic add_row(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] r,
                         input logic ge);
    row_t rw;
    rw.anchor_word = a;
    rw.row_word = r;
    rw.group_end = ge;
    row_backlog = {row_backlog, rw};
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // random junk in the unused upper bits of a register write
  function automatic logic [DATA_W-1:0] with_noise(input logic [DATA_W-1:0] v, input int w);
    logic [DATA_W-1:0] hi;
    hi = ($urandom_range(0, 3) == 0) ? ($urandom << w) : '0;
    return hi | v;
  endfunction

  localparam logic [WORD_W-1:0] ZERO_W = '0;
  localparam logic [WORD_W-1:0] ONES_W = '1;

  // stimulus
  initial begin
    int i;
    int ph;
    int ge_pct;
    logic [DATA_W-1:0] ivl;
    logic [DATA_W-1:0] ep;
    logic [DATA_W-1:0] ao;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // growing windows, then full ones, extreme words
    set_config(32'd3, 32'd1, 32'd0);
    add_row(ZERO_W, ZERO_W, 1'b0);
    add_row(ONES_W, ONES_W, 1'b0);
    add_row(ZERO_W, ONES_W, 1'b0);
    add_row(ONES_W, ZERO_W, 1'b1);

    // interval zero acts as one
    set_config(32'd0, 32'd0, 32'd0);
    add_row(rand_word(), rand_word(), 1'b0);
    add_row(rand_word(), rand_word(), 1'b1);

    // interval above the ring depth saturates; only bit 0 of the flags counts
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    for (i = 0; i < 9; i++) add_row(rand_word(), rand_word(), i == 8);

    // interval of one with tail windows: nothing extra
    set_config(32'd1, 32'd1, 32'd1);
    add_row(rand_word(), rand_word(), 1'b1);
    add_row(rand_word(), rand_word(), 1'b1);

    // tail windows after a full ring and before it fills
    set_config(32'd4, 32'd1, 32'd1);
    for (i = 0; i < 6; i++) add_row(rand_word(), rand_word(), i == 5);
    add_row(rand_word(), rand_word(), 1'b0);
    add_row(rand_word(), rand_word(), 1'b1);

    // random phases, each one rewriting the interval mid group
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin ivl = 8; ep = 1; ao = 0; end
        1: begin ivl = 1; ep = 1; ao = 1; end
        2: begin ivl = 8; ep = 1; ao = 1; end
        3: begin ivl = 1; ep = 0; ao = 0; end
        default: begin
          ivl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
          ep = $urandom_range(0, 1);
          ao = $urandom_range(0, 1);
        end
      endcase
      set_config(with_noise(ivl, 4), with_noise(ep, 1), with_noise(ao, 1));
      ge_pct = $urandom_range(3, 35);
      for (i = 0; i < 47; i++) begin
        if (ph == 5 && i == 23) hold_until_drained();
        add_row(rand_word(), rand_word(), $urandom_range(0, 99) < ge_pct);
      end
    end

    // drain and finish
    hold_until_drained();
    repeat (10) @(posedge clk);
    if (due_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", due_beats.size()));
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
